FILE: rtl/pwmc_pkg.sv
package pwmc_pkg;

    localparam int unsigned CORE_CLOCK_HZ_DEFAULT = 40000000;
    localparam int unsigned DIV_W = 32;
    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam int unsigned FREQ_W = 16;
    localparam int unsigned DUTY_W = 16;
    localparam int unsigned SAT_DUTY_W = 14;
    localparam int unsigned PER_W = 15;
    localparam int unsigned CODE_W = 2;
    localparam int unsigned CMP_W = 16;
    localparam int unsigned MASK_W = 2;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd1000;
    localparam logic [FREQ_W-1:0] DUTY_FULL = 16'd10000;
    localparam logic [PER_W-1:0] PERIOD_MAX = 15'h7FFF;
    localparam logic [CODE_W-1:0] CODE_SLOWEST = 2'd3;
    localparam logic [DIV_W-1:0] PERIOD_LIMIT = 32'd32768;

    // floor(x / 10000) == (x * DUTY_RECIP) >> DUTY_RECIP_SHIFT for any 32-bit x
    localparam logic [DIV_W-1:0] DUTY_RECIP = 32'd3518437209;
    localparam int unsigned DUTY_RECIP_SHIFT = 45;

    localparam int unsigned STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_ACCEPT = 3'd0;
    localparam step_t STEP_LOAD_FREQ = 3'd1;
    localparam step_t STEP_DIV_FREQ = 3'd2;
    localparam step_t STEP_SELECT = 3'd3;
    localparam step_t STEP_SATURATE = 3'd4;
    localparam step_t STEP_MUL_LOAD = 3'd5;
    localparam step_t STEP_SCALE = 3'd6;
    localparam step_t STEP_WRITE = 3'd7;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_LOAD_FREQ,
        OP_DIV_STEP,
        OP_SELECT,
        OP_SATURATE,
        OP_MUL_LOAD,
        OP_SCALE,
        OP_WRITE
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_FREQ_ZERO,
        COND_DIV_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_INPUT,
        HOLD_OUTPUT
    } hold_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        hold_t hold;
        step_t target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic run;
    } ctrl_t;

    typedef struct packed {
        logic freq_zero;
        logic div_busy;
        logic out_full;
    } status_t;

    function automatic uword_t ucode_word(input step_t step);
        uword_t w;
        w = '{op: OP_ACCEPT, cond: COND_NONE, hold: HOLD_INPUT, target: STEP_ACCEPT};
        case (step)
            STEP_ACCEPT: begin
                w = '{op: OP_ACCEPT, cond: COND_NONE, hold: HOLD_INPUT, target: STEP_ACCEPT};
            end
            STEP_LOAD_FREQ: begin
                w = '{op: OP_LOAD_FREQ, cond: COND_FREQ_ZERO, hold: HOLD_NONE,
                      target: STEP_SATURATE};
            end
            STEP_DIV_FREQ: begin
                w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, hold: HOLD_NONE,
                      target: STEP_DIV_FREQ};
            end
            STEP_SELECT: begin
                w = '{op: OP_SELECT, cond: COND_ALWAYS, hold: HOLD_NONE, target: STEP_MUL_LOAD};
            end
            STEP_SATURATE: begin
                w = '{op: OP_SATURATE, cond: COND_NONE, hold: HOLD_NONE, target: STEP_ACCEPT};
            end
            STEP_MUL_LOAD: begin
                w = '{op: OP_MUL_LOAD, cond: COND_NONE, hold: HOLD_NONE, target: STEP_ACCEPT};
            end
            STEP_SCALE: begin
                w = '{op: OP_SCALE, cond: COND_NONE, hold: HOLD_NONE, target: STEP_ACCEPT};
            end
            STEP_WRITE: begin
                w = '{op: OP_WRITE, cond: COND_ALWAYS, hold: HOLD_OUTPUT, target: STEP_ACCEPT};
            end
            default: begin
                w = '{op: OP_ACCEPT, cond: COND_NONE, hold: HOLD_INPUT, target: STEP_ACCEPT};
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/pwmc_sequencer.sv
module pwmc_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pwmc_pkg::status_t status,
    output pwmc_pkg::ctrl_t   ctrl
);
    import pwmc_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uword;
    logic   jump;
    logic   stall;

    assign uword = ucode_word(pc_reg);

    always_comb begin
        stall = ((uword.hold == HOLD_INPUT) && !s_valid) ||
                ((uword.hold == HOLD_OUTPUT) && status.out_full);
        jump = (uword.cond == COND_ALWAYS) ||
               ((uword.cond == COND_FREQ_ZERO) && status.freq_zero) ||
               ((uword.cond == COND_DIV_BUSY) && status.div_busy);
        if (stall) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uword.target;
        end else begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign s_ready = (uword.hold == HOLD_INPUT);
    assign ctrl.op = uword.op;
    assign ctrl.run = !stall;

    a_accept_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (pc_reg == STEP_LOAD_FREQ))
        else $error("accepted beat did not advance to frequency load");

    a_write_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_WRITE && !status.out_full) |=> (pc_reg == STEP_ACCEPT))
        else $error("write step did not return to accept");

endmodule

FILE: rtl/pwmc_datapath.sv
module pwmc_datapath #(
    parameter int unsigned CORE_CLOCK_HZ = pwmc_pkg::CORE_CLOCK_HZ_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pwmc_pkg::ctrl_t                ctrl,
    output pwmc_pkg::status_t              status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwmc_pkg::FREQ_W-1:0]    cfg_data,
    input  logic [pwmc_pkg::DUTY_W-1:0]    s_duty_hundredths,
    input  logic [pwmc_pkg::MASK_W-1:0]    s_channel_mask,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pwmc_pkg::CODE_W-1:0]    m_prescale_code,
    output logic [pwmc_pkg::PER_W-1:0]     m_period_count,
    output logic [pwmc_pkg::CMP_W-1:0]     m_duty_compare,
    output logic                           m_duty_updated
);
    import pwmc_pkg::*;

    localparam logic [DIV_W-1:0] CORE_DIVIDEND = DIV_W'(CORE_CLOCK_HZ);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);
    localparam int unsigned PROD_W = CMP_W + SAT_DUTY_W;

    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic [CMP_W-1:0]      held_reg, held_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SAT_DUTY_W-1:0] duty_reg, duty_next;
    logic                  upd_reg, upd_next;
    logic [FREQ_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic [FREQ_W-1:0]     dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [PER_W-1:0]      per_reg, per_next;
    logic [CODE_W-1:0]     m_code_reg, m_code_next;
    logic [PER_W-1:0]      m_per_reg, m_per_next;
    logic [CMP_W-1:0]      m_cmp_reg, m_cmp_next;
    logic                  m_upd_reg, m_upd_next;

    logic [FREQ_W:0]       trial;
    logic [FREQ_W:0]       trial_diff;
    logic                  trial_ge;
    logic                  sel_found;
    logic                  sel_fit;
    logic [CODE_W-1:0]     sel_code;
    logic [DIV_W-1:0]      sel_q;
    logic [DIV_W-1:0]      q_shift;
    logic [PROD_W-1:0]     product;
    logic [2*DIV_W-1:0]    scale_prod;
    logic                  do_write;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_diff = trial - {1'b0, dvsr_reg};
    assign trial_ge = (trial >= {1'b0, dvsr_reg});
    assign product = PROD_W'({per_reg, 1'b0}) * PROD_W'(duty_reg);
    assign scale_prod = {{DIV_W{1'b0}}, quo_reg} * {{DIV_W{1'b0}}, DUTY_RECIP};
    assign do_write = ctrl.run && (ctrl.op == OP_WRITE);

    always_comb begin
        sel_found = 1'b0;
        sel_code = CODE_SLOWEST;
        sel_q = '0;
        for (int k = 0; k < 4; k++) begin
            q_shift = quo_reg >> (2 * k);
            if (!sel_found && (q_shift <= PERIOD_LIMIT)) begin
                sel_found = 1'b1;
                sel_code = CODE_W'(k);
                sel_q = q_shift;
            end
        end
        sel_fit = sel_found && (sel_q != '0);
    end

    always_comb begin
        freq_next = freq_reg;
        held_next = held_reg;
        duty_next = duty_reg;
        upd_next = upd_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvsr_next = dvsr_reg;
        cnt_next = cnt_reg;
        code_next = code_reg;
        per_next = per_reg;
        m_code_next = m_code_reg;
        m_per_next = m_per_reg;
        m_cmp_next = m_cmp_reg;
        m_upd_next = m_upd_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cfg_valid) begin
            freq_next = cfg_data;
        end

        if (ctrl.run) begin
            case (ctrl.op)
                OP_ACCEPT: begin
                    duty_next = (s_duty_hundredths > DUTY_FULL) ?
                                SAT_DUTY_W'(DUTY_FULL) : s_duty_hundredths[SAT_DUTY_W-1:0];
                    upd_next = |s_channel_mask;
                end
                OP_LOAD_FREQ: begin
                    rem_next = '0;
                    quo_next = CORE_DIVIDEND;
                    dvsr_next = freq_reg;
                    cnt_next = '0;
                end
                OP_DIV_STEP: begin
                    rem_next = trial_ge ? trial_diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], trial_ge};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                OP_SELECT: begin
                    if (sel_fit) begin
                        code_next = sel_code;
                        per_next = PER_W'(sel_q - DIV_W'(1));
                    end else begin
                        code_next = CODE_SLOWEST;
                        per_next = PERIOD_MAX;
                    end
                end
                OP_SATURATE: begin
                    code_next = CODE_SLOWEST;
                    per_next = PERIOD_MAX;
                end
                OP_MUL_LOAD: begin
                    quo_next = DIV_W'(product);
                end
                OP_SCALE: begin
                    quo_next = DIV_W'(scale_prod >> DUTY_RECIP_SHIFT);
                end
                OP_WRITE: begin
                    if (upd_reg) begin
                        held_next = quo_reg[CMP_W-1:0];
                    end
                    m_code_next = code_reg;
                    m_per_next = per_reg;
                    m_cmp_next = upd_reg ? quo_reg[CMP_W-1:0] : held_reg;
                    m_upd_next = upd_reg;
                    m_valid_next = 1'b1;
                end
                default: begin
                    duty_next = duty_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= FREQ_RESET;
            held_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            freq_reg <= freq_next;
            held_reg <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        duty_reg <= duty_next;
        upd_reg <= upd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvsr_reg <= dvsr_next;
        cnt_reg <= cnt_next;
        code_reg <= code_next;
        per_reg <= per_next;
        m_code_reg <= m_code_next;
        m_per_reg <= m_per_next;
        m_cmp_reg <= m_cmp_next;
        m_upd_reg <= m_upd_next;
    end

    assign status.freq_zero = (freq_reg == '0);
    assign status.div_busy = (cnt_reg != CNT_LAST);
    assign status.out_full = m_valid_reg && !m_ready;

    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_prescale_code = m_code_reg;
    assign m_period_count = m_per_reg;
    assign m_duty_compare = m_cmp_reg;
    assign m_duty_updated = m_upd_reg;

    a_write_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |=> m_valid_reg)
        else $error("write step did not raise result valid");

    a_held_matches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_cmp_reg == held_reg))
        else $error("pending compare beat differs from held compare");

    a_held_only_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_write |=> $stable(held_reg))
        else $error("held compare changed outside a write step");

endmodule

FILE: rtl/pwm_period_and_duty_calculator_unit.sv
// PWM period and duty calculator.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the PWM frequency in hertz;
// cfg_ready is always high. Write it only while no beat is in flight.
// Input channel s_*: one beat carries a duty in 0.01 % units and a channel mask.
// Output channel m_*: one beat per input beat with prescaler code, period count,
// the held duty compare value and a flag telling whether this beat rewrote it.
// A microcoded sequencer steps a restoring divider one quotient bit per cycle
// for core clock / frequency; the 1/10000 scaling is one reciprocal multiply.
// An item steps through accept, frequency load, divide, select, multiply load, scale
// and write (a zero frequency takes a saturate step in place of divide and select).
// One item is worked on at a time. s_ready is high only in the accept step,
// which is taken even while the previous result still waits in the output
// register; the write step holds until that register drains.
// Reset (aresetn low, synchronous) sets the frequency to 1000 Hz, clears the
// held compare value, drops m_valid and restarts the program at the accept step.
module pwm_period_and_duty_calculator_unit #(
    parameter int unsigned CORE_CLOCK_HZ = pwmc_pkg::CORE_CLOCK_HZ_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwmc_pkg::FREQ_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pwmc_pkg::DUTY_W-1:0]    s_duty_hundredths,
    input  logic [pwmc_pkg::MASK_W-1:0]    s_channel_mask,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pwmc_pkg::CODE_W-1:0]    m_prescale_code,
    output logic [pwmc_pkg::PER_W-1:0]     m_period_count,
    output logic [pwmc_pkg::CMP_W-1:0]     m_duty_compare,
    output logic                           m_duty_updated
);
    import pwmc_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    pwmc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    pwmc_datapath #(
        .CORE_CLOCK_HZ (CORE_CLOCK_HZ)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_duty_hundredths (s_duty_hundredths),
        .s_channel_mask    (s_channel_mask),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_prescale_code   (m_prescale_code),
        .m_period_count    (m_period_count),
        .m_duty_compare    (m_duty_compare),
        .m_duty_updated    (m_duty_updated)
    );

endmodule
